// ===== rtl/efsd_pkg.sv =====
// Shared field widths and action codes for the earliest-free server dispatcher.
package efsd_pkg;

  // Field widths of the beats on both channels and of the configuration port.
  localparam int unsigned ACTION_W = 1;
  localparam int unsigned SRV_W    = 3;
  localparam int unsigned RATE_W   = 7;
  localparam int unsigned SIZE_W   = 7;
  localparam int unsigned CFG_W    = 4;
  localparam int unsigned OUT_T_W  = 32;
  localparam int unsigned PROD_W   = RATE_W + SIZE_W;

  // Action codes carried by an input beat.
  localparam logic [ACTION_W-1:0] ACT_LOAD = 1'b0;
  localparam logic [ACTION_W-1:0] ACT_JOB  = 1'b1;

endpackage

// ===== rtl/efsd_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module efsd_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/earliest_free_server_dispatch.sv =====
// Top level of the earliest-free server dispatcher: sequencer, scan unit and memories.
//
// Usage: an input beat either loads one server's per-unit rate (action 0) or
// submits a job (action 1). A job is placed on the active server with the
// smallest absolute free time, ties going to the lowest index, and keeps it
// busy for rate times job_size. Each job gives one output beat with the chosen
// server and its finish time; the job marked last also carries the makespan
// and clears all free times for the next batch. Times saturate at all ones.
// The user must write the server_count register through cfg_we_i / cfg_wdata_i
// only while the block is idle; the block itself does not enforce this. 0 acts as 1
// and values above MAX_SERVERS act as the max. Timing: a load beat leaves the
// sequencer idle. A job scans the free-time memory one server per cycle
// through a single comparator, then reads the rate, does one multiply and one
// saturating add, with in_ready_o low until the sequencer is idle.
// The result sits in an output register; the next item is accepted while it
// waits. If the receiver stalls, a second job waits in its final step.
// Reset clears the free times (through per-server valid bits), the latest
// finish and the output valid flag, and sets server_count to one. Rates are
// undefined until loaded.
module earliest_free_server_dispatch import efsd_pkg::*; #(
  parameter int unsigned MAX_SERVERS = 8,
  parameter int unsigned TIME_BITS   = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration port
  input  logic                cfg_we_i,
  input  logic [CFG_W-1:0]    cfg_wdata_i,
  // Input channel
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [ACTION_W-1:0] action_i,
  input  logic [SRV_W-1:0]    server_index_i,
  input  logic [RATE_W-1:0]   rate_i,
  input  logic [SIZE_W-1:0]   job_size_i,
  input  logic                last_job_i,
  // Output channel
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [SRV_W-1:0]    assigned_server_o,
  output logic [OUT_T_W-1:0]  finish_time_o,
  output logic [OUT_T_W-1:0]  makespan_o,
  output logic                batch_done_o
);

  localparam int unsigned IdxW = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
  localparam int unsigned CntW = $clog2(MAX_SERVERS + 1);

  // Sequencer states.
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_MUL  = 2'd2;
  localparam logic [1:0] ST_ADD  = 2'd3;

  logic [1:0]             state_q, state_d;
  logic [CFG_W-1:0]       server_count_q;
  logic [CntW-1:0]        count_q, count_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic [IdxW-1:0]        didx_q, didx_d;
  logic [MAX_SERVERS-1:0] fvalid_q, fvalid_d;
  logic [TIME_BITS-1:0]   latest_q, latest_d;
  logic [TIME_BITS-1:0]   best_time_q, best_time_d;
  logic [IdxW-1:0]        best_idx_q, best_idx_d;
  logic [SIZE_W-1:0]      size_q, size_d;
  logic                   last_q, last_d;
  logic [PROD_W-1:0]      prod_q, prod_d;
  logic                   out_valid_q, out_valid_d;
  logic [SRV_W-1:0]       out_srv_q, out_srv_d;
  logic [OUT_T_W-1:0]     out_fin_q, out_fin_d;
  logic [OUT_T_W-1:0]     out_mk_q, out_mk_d;
  logic                   out_done_q, out_done_d;

  logic                   in_acc;
  logic                   out_free;
  logic [CntW-1:0]        count_eff;
  logic [TIME_BITS-1:0]   free_rdata;
  logic [TIME_BITS-1:0]   cur_time;
  logic                   take;
  logic                   last_scan;
  logic [IdxW-1:0]        free_raddr;
  logic                   free_we;
  logic [RATE_W-1:0]      rate_rdata;
  logic                   rate_we;
  logic [TIME_BITS:0]     sum;
  logic [TIME_BITS-1:0]   finish;
  logic [TIME_BITS-1:0]   new_latest;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // Clamp the configured server count into 1 .. MAX_SERVERS.
  always_comb begin
    priority if (server_count_q == '0) begin
      count_eff = CntW'(1);
    end else if (32'(server_count_q) > MAX_SERVERS) begin
      count_eff = CntW'(MAX_SERVERS);
    end else begin
      count_eff = CntW'(server_count_q);
    end
  end

  // Rate memory: written by load beats, read once per job at the chosen server.
  assign rate_we = in_acc && (action_i == ACT_LOAD) && (32'(server_index_i) < MAX_SERVERS);

  efsd_ram #(
    .WIDTH (RATE_W),
    .DEPTH (MAX_SERVERS)
  ) u_rate_ram (
    .clk_i   (clk_i),
    .we_i    (rate_we),
    .waddr_i (IdxW'(server_index_i)),
    .wdata_i (rate_i),
    .raddr_i (best_idx_d),
    .rdata_o (rate_rdata)
  );

  // Free-time memory: scanned one entry per cycle, written back at the end of a job.
  always_comb begin
    if (state_q == ST_SCAN && cnt_q < count_q) begin
      free_raddr = cnt_q[IdxW-1:0];
    end else begin
      free_raddr = '0;
    end
  end

  assign free_we = (state_q == ST_ADD) && out_free;

  efsd_ram #(
    .WIDTH (TIME_BITS),
    .DEPTH (MAX_SERVERS)
  ) u_free_ram (
    .clk_i   (clk_i),
    .we_i    (free_we),
    .waddr_i (best_idx_q),
    .wdata_i (finish),
    .raddr_i (free_raddr),
    .rdata_o (free_rdata)
  );

  // Scan comparator: an entry never written in this batch reads as zero.
  assign cur_time  = fvalid_q[didx_q] ? free_rdata : '0;
  assign take      = (didx_q == '0) || (cur_time < best_time_q);
  assign last_scan = (CntW'(didx_q) == count_q - CntW'(1));

  // Saturating add of the job duration onto the chosen server's free time.
  assign sum        = {1'b0, best_time_q} + (TIME_BITS + 1)'(prod_q);
  assign finish     = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];
  assign new_latest = (finish > latest_q) ? finish : latest_q;

  // Sequencer next-state logic.
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    cnt_d       = cnt_q;
    didx_d      = didx_q;
    fvalid_d    = fvalid_q;
    latest_d    = latest_q;
    best_time_d = best_time_q;
    best_idx_d  = best_idx_q;
    size_d      = size_q;
    last_d      = last_q;
    prod_d      = prod_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_srv_d   = out_srv_q;
    out_fin_d   = out_fin_q;
    out_mk_d    = out_mk_q;
    out_done_d  = out_done_q;

    unique case (state_q)
      ST_IDLE: begin
        // A job beat starts the scan; address zero is read this cycle.
        if (in_acc && action_i == ACT_JOB) begin
          state_d = ST_SCAN;
          count_d = count_eff;
          cnt_d   = CntW'(1);
          didx_d  = '0;
          size_d  = job_size_i;
          last_d  = last_job_i;
        end
      end
      ST_SCAN: begin
        if (take) begin
          best_time_d = cur_time;
          best_idx_d  = didx_q;
        end
        didx_d = cnt_q[IdxW-1:0];
        cnt_d  = cnt_q + CntW'(1);
        if (last_scan) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        prod_d  = PROD_W'(rate_rdata) * PROD_W'(size_q);
        state_d = ST_ADD;
      end
      ST_ADD: begin
        // Retire the job into the output register once it is free.
        if (out_free) begin
          out_valid_d = 1'b1;
          out_srv_d   = SRV_W'(best_idx_q);
          out_fin_d   = OUT_T_W'(finish);
          out_mk_d    = last_q ? OUT_T_W'(new_latest) : '0;
          out_done_d  = last_q;
          state_d     = ST_IDLE;
          if (last_q) begin
            fvalid_d = '0;
            latest_d = '0;
          end else begin
            fvalid_d[best_idx_q] = 1'b1;
            latest_d             = new_latest;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      server_count_q <= CFG_W'(1);
      fvalid_q       <= '0;
      latest_q       <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      fvalid_q    <= fvalid_d;
      latest_q    <= latest_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        server_count_q <= cfg_wdata_i;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    count_q     <= count_d;
    cnt_q       <= cnt_d;
    didx_q      <= didx_d;
    best_time_q <= best_time_d;
    best_idx_q  <= best_idx_d;
    size_q      <= size_d;
    last_q      <= last_d;
    prod_q      <= prod_d;
    out_srv_q   <= out_srv_d;
    out_fin_q   <= out_fin_d;
    out_mk_q    <= out_mk_d;
    out_done_q  <= out_done_d;
  end

  assign out_valid_o       = out_valid_q;
  assign assigned_server_o = out_srv_q;
  assign finish_time_o     = out_fin_q;
  assign makespan_o        = out_mk_q;
  assign batch_done_o      = out_done_q;

endmodule

// ===== rtl/efsd_checker.sv =====
// Port-level assertions for the earliest-free server dispatcher, bound to the top level.
module efsd_checker import efsd_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic [ACTION_W-1:0] action_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input logic [OUT_T_W-1:0]  finish_time_o,
  input logic [OUT_T_W-1:0]  makespan_o,
  input logic                batch_done_o
);

  // A job beat keeps the sequencer busy for at least the scan.
  a_job_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && action_i == ACT_JOB) |=> !in_ready_o)
    else $error("ready stayed high after a job beat");

  // A load beat leaves the sequencer ready for the next beat.
  a_load_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && action_i == ACT_LOAD) |=> in_ready_o)
    else $error("ready dropped after a load beat");

  // A result beat is held until the receiver takes it.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(finish_time_o)))
    else $error("stalled result beat changed");

  // The makespan is zero unless the beat closes a batch.
  a_mk_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !batch_done_o) |-> (makespan_o == '0))
    else $error("makespan set on a beat that does not close the batch");

  // The makespan covers the finish time of the closing job.
  a_mk_cover: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && batch_done_o) |-> (makespan_o >= finish_time_o))
    else $error("makespan below the closing job's finish time");

endmodule

bind earliest_free_server_dispatch efsd_checker u_efsd_checker (.*);

// ===== tb/earliest_free_server_dispatch_test.sv =====
// Self-checking testbench for the earliest-free server dispatcher with its own scheduling model.
module earliest_free_server_dispatch_test;
  timeunit 1ns;
  timeprecision 1ps;

  import efsd_pkg::*;

  localparam int unsigned NUM_SERVERS     = 8;
  localparam int unsigned CLK_HALF        = 6;
  localparam int unsigned RESET_CYCLES    = 5;
  // Long enough to cover one job in flight plus a load.
  localparam int unsigned SETTLE_CYCLES   = 24;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned QUIET_LIMIT     = 4000;
  localparam int unsigned MAX_REPORTS     = 10;
  localparam logic [OUT_T_W-1:0] TIME_CEIL = '1;

  // One job result as the scheduler model predicts it.
  typedef struct packed {
    logic [SRV_W-1:0]   server;
    logic [OUT_T_W-1:0] finish;
    logic [OUT_T_W-1:0] makespan;
    logic               done;
  } dispatch_t;

  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                cfg_we_i       = 1'b0;
  logic [CFG_W-1:0]    cfg_wdata_i    = '0;
  logic                in_valid_i     = 1'b0;
  logic                in_ready_o;
  logic [ACTION_W-1:0] action_i       = ACT_LOAD;
  logic [SRV_W-1:0]    server_index_i = '0;
  logic [RATE_W-1:0]   rate_i         = '0;
  logic [SIZE_W-1:0]   job_size_i     = '0;
  logic                last_job_i     = 1'b0;
  logic                out_valid_o;
  logic                out_ready_i    = 1'b0;
  logic [SRV_W-1:0]    assigned_server_o;
  logic [OUT_T_W-1:0]  finish_time_o;
  logic [OUT_T_W-1:0]  makespan_o;
  logic                batch_done_o;

  // Scheduler model state.
  logic [CFG_W-1:0]    active_cfg = 4'd1;
  logic [RATE_W-1:0]   rate_tab [NUM_SERVERS];
  logic [OUT_T_W-1:0]  free_at  [NUM_SERVERS];
  logic [OUT_T_W-1:0]  batch_peak = '0;
  dispatch_t           pending_dispatches [$];

  // Traffic shaping and bookkeeping.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_left     = 0;
  int unsigned quiet_cycles  = 0;
  int unsigned mismatches    = 0;
  int unsigned results_seen  = 0;
  int unsigned jobs_sent     = 0;
  int unsigned loads_sent    = 0;
  int unsigned batches_done  = 0;
  int unsigned counts_written = 0;

  earliest_free_server_dispatch DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .action_i          (action_i),
    .server_index_i    (server_index_i),
    .rate_i            (rate_i),
    .job_size_i        (job_size_i),
    .last_job_i        (last_job_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .assigned_server_o (assigned_server_o),
    .finish_time_o     (finish_time_o),
    .makespan_o        (makespan_o),
    .batch_done_o      (batch_done_o)
  );

  initial begin
    forever #(CLK_HALF) clk_i = ~clk_i;
  end

  // Places one job on the earliest-free active server and returns its result.
  function automatic dispatch_t dispatch_job(input logic [SIZE_W-1:0] size, input logic last);
    dispatch_t   res;
    int unsigned span;
    int unsigned pick;
    logic [63:0] total;
    span = (active_cfg == 0) ? 1 : ((active_cfg > NUM_SERVERS) ? NUM_SERVERS : active_cfg);
    pick = 0;
    for (int unsigned s = 1; s < span; s++) begin
      if (free_at[s] < free_at[pick]) pick = s;
    end
    // Busy time is rate times size on top of the free time, capped at all ones.
    total = 64'(free_at[pick]) + 64'(rate_tab[pick]) * 64'(size);
    if (total > 64'(TIME_CEIL)) total = 64'(TIME_CEIL);
    free_at[pick] = total[OUT_T_W-1:0];
    if (free_at[pick] > batch_peak) batch_peak = free_at[pick];
    res.server   = pick[SRV_W-1:0];
    res.finish   = free_at[pick];
    res.makespan = last ? batch_peak : '0;
    res.done     = last;
    // Closing a batch starts every server from time zero again.
    if (last) begin
      foreach (free_at[s]) free_at[s] = '0;
      batch_peak = '0;
    end
    return res;
  endfunction

  // Rate or size: mostly 1 to 100, sometimes zero or 101 to 127.
  function automatic logic [RATE_W-1:0] pick_field();
    case ($urandom_range(9))
      0: return '0;
      1: return RATE_W'($urandom_range(127, 101));
      default: return RATE_W'($urandom_range(100, 1));
    endcase
  endfunction

  // Server count including zero and values past the bank size.
  function automatic logic [CFG_W-1:0] pick_count();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2: return CFG_W'($urandom_range(14, 9));
      default: return CFG_W'($urandom_range(8, 1));
    endcase
  endfunction

  // Sends one beat after a random gap and updates the model when it is taken.
  task automatic send_beat(input logic [ACTION_W-1:0] act, input logic [SRV_W-1:0] idx,
                           input logic [RATE_W-1:0] rt, input logic [SIZE_W-1:0] sz,
                           input logic lst);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i     <= 1'b0;
      action_i       <= ACTION_W'($urandom);
      server_index_i <= SRV_W'($urandom);
      rate_i         <= RATE_W'($urandom);
      job_size_i     <= SIZE_W'($urandom);
      last_job_i     <= 1'($urandom);
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    action_i       <= act;
    server_index_i <= idx;
    rate_i         <= rt;
    job_size_i     <= sz;
    last_job_i     <= lst;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (act == ACT_JOB) begin
      pending_dispatches.push_back(dispatch_job(sz, lst));
      jobs_sent++;
      if (lst) batches_done++;
    end else begin
      rate_tab[idx] = rt;
      loads_sent++;
    end
  endtask

  // Job beat; the load-only fields carry random values.
  task automatic send_job(input logic [SIZE_W-1:0] sz, input logic lst);
    send_beat(ACT_JOB, SRV_W'($urandom), RATE_W'($urandom), sz, lst);
  endtask

  // Rate load; the job-only fields carry random values.
  task automatic send_load(input logic [SRV_W-1:0] idx, input logic [RATE_W-1:0] rt);
    send_beat(ACT_LOAD, idx, rt, SIZE_W'($urandom), 1'($urandom));
  endtask

  // Stops offering beats until every predicted result is out and the block is quiet.
  task automatic wait_drained();
    if (in_valid_i) in_valid_i <= 1'b0;
    while (pending_dispatches.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Writes server_count once the block is idle.
  task automatic set_server_count(input logic [CFG_W-1:0] value);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    active_cfg = value;
    counts_written++;
  endtask

  // Every server gets a rate before any job can reach it, including zero and all ones.
  task automatic test_rate_loads();
    send_load(3'd0, 7'd1);
    send_load(3'd1, 7'd100);
    send_load(3'd2, 7'd127);
    send_load(3'd3, 7'd0);
    send_load(3'd4, 7'd2);
    send_load(3'd5, 7'd3);
    send_load(3'd6, 7'd64);
    send_load(3'd7, 7'd50);
  endtask

  // Hand-picked batches over the server-count extremes and tie cases.
  task automatic test_directed_jobs();
    // Reset count of one: every job lands on server zero.
    send_job(7'd1, 1'b0);
    send_job(7'd127, 1'b1);
    // Full bank from idle: zero-size job, ties to the lowest index, a zero-rate server
    // that never gets busier, then a rate reload in the middle of the batch.
    set_server_count(4'd8);
    send_job(7'd0, 1'b0);
    send_job(7'd10, 1'b0);
    send_job(7'd20, 1'b0);
    send_job(7'd5, 1'b0);
    send_job(7'd9, 1'b0);
    send_job(7'd50, 1'b0);
    send_load(3'd3, 7'd5);
    send_job(7'd3, 1'b0);
    send_job(7'd127, 1'b1);
    // A count of zero behaves as one.
    set_server_count(4'd0);
    send_job(7'd4, 1'b0);
    send_job(7'd6, 1'b1);
    // Counts past the bank behave as the full bank.
    set_server_count(4'd15);
    send_job(7'd100, 1'b0);
    send_job(7'd100, 1'b0);
    send_job(7'd100, 1'b1);
    set_server_count(4'd9);
    send_job(7'd64, 1'b1);
  endtask

  // Closed batches of random length with rate reloads mixed in and count changes between.
  task automatic test_random_traffic(input int unsigned n_items);
    int unsigned sent;
    int unsigned jobs_left;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(3) == 0) set_server_count(pick_count());
      jobs_left = $urandom_range(12, 1);
      while (jobs_left > 0) begin
        if ($urandom_range(99) < 12) begin
          send_load(SRV_W'($urandom_range(NUM_SERVERS - 1)), pick_field());
        end else begin
          jobs_left--;
          send_job(pick_field(), jobs_left == 0);
        end
        sent++;
      end
    end
  endtask

  // The receiver holds off while jobs keep coming, so the input side must stall.
  task automatic test_output_hold_off();
    set_server_count(4'd2);
    hold_left = HOLD_OFF_CYCLES;
    for (int k = 0; k < 16; k++) begin
      send_job(pick_field(), k == 15);
    end
    wait_drained();
  endtask

  // The sender stops mid-batch until all results are back; free times carry over.
  task automatic test_sender_pause();
    set_server_count(4'd8);
    for (int k = 0; k < 6; k++) begin
      send_job(pick_field(), 1'b0);
    end
    wait_drained();
    for (int k = 0; k < 6; k++) begin
      send_job(pick_field(), k == 5);
    end
    wait_drained();
  endtask

  // Output-side ready: a long hold-off when requested, otherwise random stalls.
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_ready_i <= 1'b0;
      hold_left--;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compares each output beat with the oldest predicted result.
  always @(posedge clk_i) begin : check_results
    dispatch_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (pending_dispatches.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("%0t: result with no job waiting: server %0d finish %0d makespan %0d done %0b",
                   $realtime, assigned_server_o, finish_time_o, makespan_o, batch_done_o);
        end
      end else begin
        want = pending_dispatches.pop_front();
        if (assigned_server_o !== want.server || finish_time_o !== want.finish ||
            makespan_o !== want.makespan || batch_done_o !== want.done) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("%0t: mismatch: expected server %0d finish %0d makespan %0d done %0b",
                     $realtime, want.server, want.finish, want.makespan, want.done);
            $display("%0t:           actual   server %0d finish %0d makespan %0d done %0b",
                     $realtime, assigned_server_o, finish_time_o, makespan_o, batch_done_o);
          end
        end
      end
    end
  end

  // Ends the run when neither channel has moved a beat for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timeout: no beat moved for %0d cycles, %0d results outstanding",
               QUIET_LIMIT, pending_dispatches.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Test sequence.
  initial begin
    foreach (rate_tab[s]) rate_tab[s] = '0;
    foreach (free_at[s]) free_at[s] = '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Sender idles a third of the time, receiver two thirds.
    send_idle_pct = 34;
    recv_idle_pct = 67;
    test_rate_loads();
    test_directed_jobs();
    test_random_traffic(330);

    // Roles swapped.
    send_idle_pct = 67;
    recv_idle_pct = 34;
    test_random_traffic(330);
    test_output_hold_off();

    // Neither side idles.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(330);
    test_sender_pause();

    wait_drained();
    $display("Covered %0d jobs in %0d batches, %0d rate loads and %0d server-count writes,",
             jobs_sent, batches_done, loads_sent, counts_written);
    $display("three idle mixes, an output hold-off and a sender pause; %0d results checked.",
             results_seen);
    if (pending_dispatches.size() != 0) begin
      $display("%0d jobs never produced a result", pending_dispatches.size());
    end
    if (mismatches == 0 && pending_dispatches.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
